/* hdl/bqwd_pkg.sv */
package bqwd_pkg;

   localparam int unsigned WeightsPerBlock = 32;
   localparam int unsigned HalfBlock = WeightsPerBlock / 2;
   localparam logic [5:0] Q8BlockLen = 6'd34;
   localparam logic [5:0] Q4BlockLen = 6'd18;
   localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ExpAllOnes = 64'h7FF0_0000_0000_0000;

   typedef enum logic [0:0] {
      FMT_Q8 = 1'b0,
      FMT_Q4 = 1'b1
   } format_type;

   typedef enum logic [0:0] {
      CSR_FORMAT = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_index_type;

   // One pending weight handed from the parser to the converter.
   typedef struct packed {
      logic [15:0] scale;
      logic [4:0]  qval;
      logic        last;
   } work_type;

   // Exact product of a binary16 scale and a signed integer (-128..127) as binary64.
   function automatic logic [63:0] scaled_weight(input logic [15:0] half,
                                                 input logic signed [7:0] q);
      logic        hsign;
      logic [4:0]  ex;
      logic [9:0]  mn;
      logic        qsign;
      logic [7:0]  qmag;
      logic        sgn;
      logic [10:0] m;
      logic [18:0] p;
      logic [4:0]  top;
      logic [10:0] expo;
      logic [51:0] frac;
      logic [70:0] shifted;
      hsign = half[15];
      ex = half[14:10];
      mn = half[9:0];
      qsign = q[7];
      qmag = q[7] ? 8'(-q) : 8'(q);
      sgn = hsign ^ qsign;
      m = (ex == 5'd0) ? {1'b0, mn} : {1'b1, mn};
      p = 19'(m) * 19'(qmag);
      top = 5'd0;
      for (int i = 0; i < 19; i++) begin
         if (p[i]) top = 5'(i);
      end
      expo = (ex == 5'd0) ? 11'(11'd999 + 11'(top))
                          : 11'(11'd998 + 11'(ex) + 11'(top));
      shifted = {52'd0, p} << (7'd52 - 7'(top));
      frac = shifted[51:0];
      if (ex == 5'h1F) begin
         if (mn != 10'd0) scaled_weight = {hsign, 63'd0} | DefaultNan | {12'd0, mn, 42'd0};
         else if (qmag == 8'd0) scaled_weight = DefaultNan;
         else scaled_weight = {sgn, 63'd0} | ExpAllOnes;
      end else if (p == 19'd0) begin
         scaled_weight = {sgn, 63'd0};
      end else begin
         scaled_weight = {sgn, expo, frac};
      end
   endfunction

endpackage

/* hdl/bqwd_front.sv */
module bqwd_front import bqwd_pkg::*; #(
   parameter int unsigned INDEX_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [39:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   output logic                  q_valid,
   input  logic                  q_stall,
   output logic [7:0]            q_byte,
   output logic [15:0]           q_scale,
   output logic                  q_emit0,
   output logic                  q_emit1,
   output logic [INDEX_BITS-1:0] q_idx0,
   output logic [INDEX_BITS-1:0] q_idx1,
   output format_type            q_format
);
   localparam int unsigned BnBits = INDEX_BITS - 5;

   format_type            format_ff;
   logic [39:0]           count_ff;
   logic [5:0]            pos_ff, pos_in;
   logic [BnBits-1:0]     bn_ff, bn_in;
   logic [15:0]           scale_ff, scale_in;
   logic                  vld_ff;
   logic [7:0]            byte_ff;
   logic [15:0]           qscale_ff;
   logic                  e0_ff, e1_ff;
   logic [INDEX_BITS-1:0] i0_ff, i1_ff;
   format_type            qfmt_ff;
   logic                  accept, is_data, e0, e1;
   logic [INDEX_BITS-1:0] i0, i1;
   logic [5:0]            blen;
   logic [48:0]           c0, c1, cnt;

   assign req_stall = vld_ff && q_stall;
   assign accept = req_valid && !req_stall;
   assign blen = (format_ff == FMT_Q4) ? Q4BlockLen : Q8BlockLen;
   assign is_data = pos_ff >= 6'd2;
   assign i0 = {bn_ff, 5'd0} + INDEX_BITS'(pos_ff - 6'd2);
   assign i1 = i0 + INDEX_BITS'(HalfBlock);
   assign c0 = 49'(i0);
   assign c1 = 49'(i1);
   assign cnt = 49'(count_ff);
   assign e0 = is_data && (c0 < cnt);
   assign e1 = is_data && (format_ff == FMT_Q4) && (c1 < cnt);

   always_comb begin
      scale_in = scale_ff;
      if (pos_ff == 6'd0) scale_in = {scale_ff[15:8], req_data_byte};
      else if (pos_ff == 6'd1) scale_in = {req_data_byte, scale_ff[7:0]};
      if (pos_ff + 6'd1 >= blen) begin
         pos_in = 6'd0;
         bn_in = bn_ff + BnBits'(1);
      end else begin
         pos_in = pos_ff + 6'd1;
         bn_in = bn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_Q8;
         count_ff <= '0;
         pos_ff <= '0;
         bn_ff <= '0;
         scale_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            bn_ff <= bn_in;
            scale_ff <= scale_in;
            vld_ff <= e0 || e1;
         end else if (!q_stall) begin
            vld_ff <= 1'b0;
         end
         if (csr_write && csr_index == CSR_FORMAT) begin
            format_ff <= format_type'(csr_data[0]);
            pos_ff <= '0;
            bn_ff <= '0;
         end
         if (csr_write && csr_index == CSR_COUNT) count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
         qscale_ff <= scale_ff;
         e0_ff <= e0;
         e1_ff <= e1;
         i0_ff <= i0;
         i1_ff <= i1;
         qfmt_ff <= format_ff;
      end
   end

   assign q_valid = vld_ff;
   assign q_byte = byte_ff;
   assign q_scale = qscale_ff;
   assign q_emit0 = e0_ff;
   assign q_emit1 = e1_ff;
   assign q_idx0 = i0_ff;
   assign q_idx1 = i1_ff;
   assign q_format = qfmt_ff;
endmodule

/* hdl/bqwd_back.sv */
module bqwd_back import bqwd_pkg::*; #(
   parameter int unsigned INDEX_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_stall,
   input  logic [7:0]            q_byte,
   input  logic [15:0]           q_scale,
   input  logic                  q_emit0,
   input  logic                  q_emit1,
   input  logic [INDEX_BITS-1:0] q_idx0,
   input  logic [INDEX_BITS-1:0] q_idx1,
   input  format_type            q_format,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_weight_bits,
   output logic [39:0]           rsp_weight_index,
   output logic                  rsp_last_in_item
);
   // Pending second weight of a q4_0 pair.
   logic                  hold_ff;
   work_type              hw_ff;
   logic [INDEX_BITS-1:0] hidx_ff;
   logic                  ov_ff;
   logic [63:0]           bits_ff;
   logic [39:0]           idx_ff;
   logic                  last_ff;
   logic                  out_free, take;
   logic signed [7:0]     q;
   logic [15:0]           sc;
   logic [INDEX_BITS-1:0] ix;
   logic                  lst;

   assign out_free = !ov_ff || !rsp_stall;
   assign take = q_valid && out_free && !hold_ff;
   assign q_stall = !(out_free && !hold_ff);

   always_comb begin
      if (hold_ff) begin
         q = 8'(signed'(hw_ff.qval));
         sc = hw_ff.scale;
         ix = hidx_ff;
         lst = hw_ff.last;
      end else if (q_format == FMT_Q4) begin
         if (q_emit0) begin
            q = 8'(signed'({1'b0, q_byte[3:0]})) - 8'sd8;
            ix = q_idx0;
            lst = !q_emit1;
         end else begin
            q = 8'(signed'({1'b0, q_byte[7:4]})) - 8'sd8;
            ix = q_idx1;
            lst = 1'b1;
         end
         sc = q_scale;
      end else begin
         q = signed'(q_byte);
         sc = q_scale;
         ix = q_idx0;
         lst = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (out_free) begin
         ov_ff <= hold_ff || q_valid;
         if (hold_ff) hold_ff <= 1'b0;
         else if (take) hold_ff <= q_format == FMT_Q4 && q_emit0 && q_emit1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && (hold_ff || q_valid)) begin
         bits_ff <= scaled_weight(sc, q);
         idx_ff <= 40'(ix);
         last_ff <= lst;
      end
      if (take) begin
         hw_ff.scale <= q_scale;
         hw_ff.qval <= 5'(signed'({1'b0, q_byte[7:4]}) - 6'sd8);
         hw_ff.last <= 1'b1;
         hidx_ff <= q_idx1;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_weight_bits = bits_ff;
   assign rsp_weight_index = idx_ff;
   assign rsp_last_in_item = last_ff;
endmodule

/* hdl/block_quant_weight_dequantizer.sv */
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_data_byte
// rsp      out        rsp_valid/stall    rsp_weight_bits, rsp_weight_index, rsp_last_in_item
// A q8_0 byte yields one weight; a q4_0 byte yields up to two, which leave in turn through the single result register.
// From acceptance, a byte passes the front register and then the result register.
// Reset is synchronous and returns the parser to byte 0 of block 0.
// The front stage stalls only while its register is full and the back stage stalls.
module block_quant_weight_dequantizer import bqwd_pkg::*; #(
   parameter int unsigned INDEX_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [39:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_weight_bits,
   output logic [39:0] rsp_weight_index,
   output logic        rsp_last_in_item
);
   logic                  q_valid, q_stall, q_emit0, q_emit1;
   logic [7:0]            q_byte;
   logic [15:0]           q_scale;
   logic [INDEX_BITS-1:0] q_idx0, q_idx1;
   format_type            q_format;

   bqwd_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_data_byte,
      .q_valid, .q_stall, .q_byte, .q_scale, .q_emit0, .q_emit1,
      .q_idx0, .q_idx1, .q_format
   );

   bqwd_back #(.INDEX_BITS(INDEX_BITS)) u_back (
      .clock, .reset,
      .q_valid, .q_stall, .q_byte, .q_scale, .q_emit0, .q_emit1,
      .q_idx0, .q_idx1, .q_format,
      .rsp_valid, .rsp_stall, .rsp_weight_bits, .rsp_weight_index, .rsp_last_in_item
   );

`ifndef SYNTH
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_bits))
      else $error("result changed while stalled");
   a_q4_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_in_item |=> rsp_valid && rsp_last_in_item)
      else $error("second weight of pair missing");
   a_no_req_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");
`endif
endmodule
